/* hw/rtl/b2da_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned CHAR_W  = 6;

    localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;

    // per-cell control, driven by the sequencer to every cell of the chain
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/b2da_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module b2da_cell (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire  b2da_pkg::cell_ctrl_t          ctrl,
    input  wire                                 carry_in,
    input  wire  [b2da_pkg::DIGIT_W-1:0]        digit_in,
    output logic                                carry_out,
    output logic [b2da_pkg::DIGIT_W-1:0]        digit
);

    logic [b2da_pkg::DIGIT_W-1:0] digit_reg;
    logic [b2da_pkg::DIGIT_W-1:0] digit_next;
    logic [b2da_pkg::DIGIT_W-1:0] adj;

    // add three before the shift when the digit would overflow past nine
    assign adj       = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign carry_out = adj[b2da_pkg::DIGIT_W-1];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[b2da_pkg::DIGIT_W-2:0], carry_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/binary_to_decimal_ascii_top.sv */
// Binary to decimal ASCII converter.
// Input channel: value with value_valid / value_stall; a request is taken when
// value_valid is high and value_stall is low. Only the low VALUE_WIDTH bits count.
// Output channel: digit_char and last with char_valid / char_stall; one request
// per decimal digit, most significant first, leading zeros dropped, last set on
// the final digit. Zero gives the single character '0'.
// Timing: after a request is taken the double-dabble chain of NUM_DIGITS BCD
// cells runs one bit per cycle over all VALUE_WIDTH bits. Leading zero cells are
// then shifted out at one cell a cycle, and emission starts after that.
// Characters follow at one per cycle while char_stall is low.
// value_stall is high from the taken request until the last character has been
// loaded into the output register; the next value is taken while that last
// character still waits.
// A stalled receiver holds the output register and pauses digit emission.
// Reset clears the sequencer, the cells and any pending output character.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii_top #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              value_valid,
    output logic                             value_stall,
    input  wire  [63:0]                      value,
    output logic                             char_valid,
    input  wire                              char_stall,
    output logic [b2da_pkg::CHAR_W-1:0]      digit_char,
    output logic                             last
);

    // floor(w * log10(2)) + 1 decimal digits cover a w-bit value
    localparam int unsigned NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int unsigned BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int unsigned REM_W      = $clog2(NUM_DIGITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [VALUE_WIDTH-1:0]        bin_reg, bin_next;
    logic [BIT_CNT_W-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic                          char_valid_reg, char_valid_next;
    logic [b2da_pkg::CHAR_W-1:0]   char_reg, char_next;
    logic                          last_reg, last_next;

    b2da_pkg::cell_ctrl_t          ctrl;
    logic [NUM_DIGITS:0]           carry;
    logic [b2da_pkg::DIGIT_W-1:0]  digits [NUM_DIGITS];
    logic [b2da_pkg::DIGIT_W-1:0]  top_digit;
    logic                          accept;
    logic                          out_free;
    logic                          load;

    assign carry[0]  = bin_reg[VALUE_WIDTH-1];
    assign top_digit = digits[NUM_DIGITS-1];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++)
        begin : g_cell
            logic [b2da_pkg::DIGIT_W-1:0] lower;
            if (gi == 0)
            begin : g_first
                assign lower = '0;
            end
            else
            begin : g_rest
                assign lower = digits[gi-1];
            end
            b2da_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .carry_in  (carry[gi]),
                .digit_in  (lower),
                .carry_out (carry[gi+1]),
                .digit     (digits[gi])
            );
        end
    endgenerate

    assign value_stall = (state_reg != ST_IDLE);
    assign accept      = value_valid && !value_stall;
    assign out_free    = !char_valid_reg || !char_stall;
    assign load        = (state_reg == ST_EMIT) && out_free;

    always_comb
    begin
        state_next      = state_reg;
        bin_next        = bin_reg;
        bit_cnt_next    = bit_cnt_reg;
        rem_next        = rem_reg;
        char_next       = char_reg;
        last_next       = last_reg;
        char_valid_next = char_valid_reg && char_stall;
        ctrl            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bin_next     = value[VALUE_WIDTH-1:0];
                    bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH);
                    ctrl.clear   = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.dabble  = 1'b1;
                bin_next     = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    rem_next   = REM_W'(NUM_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if ((top_digit == '0) && (rem_reg != REM_W'(1)))
                begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    char_next       = b2da_pkg::DIGIT_BASE + {2'b00, top_digit};
                    last_next       = (rem_reg == REM_W'(1));
                    char_valid_next = 1'b1;
                    ctrl.shift      = 1'b1;
                    rem_next        = rem_reg - 1'b1;
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bit_cnt_reg    <= '0;
            rem_reg        <= '0;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bit_cnt_reg    <= bit_cnt_next;
            rem_reg        <= rem_next;
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign char_valid = char_valid_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;

    a_conv_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (bit_cnt_reg != '0))
        else $error("conversion running with empty bit count");

    a_rem_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SKIP) || (state_reg == ST_EMIT)) |-> (rem_reg != '0))
        else $error("digit count exhausted before last character");

    a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CONV) && (bit_cnt_reg == BIT_CNT_W'(1))) |=> (state_reg == ST_SKIP))
        else $error("conversion did not end after last bit");

    a_last_load: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (rem_reg == REM_W'(1))) |=> (char_valid_reg && last_reg && state_reg == ST_IDLE))
        else $error("final character not flagged last");

    a_top_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> !carry[NUM_DIGITS])
        else $error("top digit cell overflowed");

endmodule

`default_nettype wire
